// File: hdl/skte_pkg.sv
package skte_pkg;

  localparam int KEY_W          = 30;
  localparam int IN_DATA_W      = 32;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int POS_W          = 8;
  localparam int FOUND_W        = 32;
  localparam int CAP_W          = 9;
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 40;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_UPSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SEEK,
    CS_CMP,
    CS_DECIDE,
    CS_MV_RD,
    CS_MV_WR,
    CS_PUT,
    CS_DONE
  } ctl_state_t;

  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     position;
    logic [FOUND_W-1:0]   found_data;
  } res_t;

endpackage

// File: hdl/sorted_key_table_engine_top.sv
// Sorted key table: entries are kept in ascending key order in one single-port-write,
// registered-read RAM, and every request is served one at a time. An item takes
// a binary search and a reply, plus a RAM read and a write for each entry moved
// by an insert (entries at and above the insert point) or a delete (entries
// above the removed one), plus the insert write itself. Each search probe and
// each moved entry waits on a registered RAM read. A finished result waits in
// an output register, so the next request is taken while it is pending.
// No clearing pass is needed after reset.
module sorted_key_table_engine_top
  import skte_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key[29:0], entry_data[61:30], zero fill
  input  logic [FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position[7:0], found_data[39:8]
  output logic [STATUS_W-1:0]    out_tuser,  // status[1:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data    // capacity
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int ENT_W = KEY_W + DATA_WIDTH;

  logic [CAP_W-1:0] capacity_r;
  logic             out_valid_r;
  res_t             out_res_r;

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity_r <= cfg_data;
    end
  end

  skte_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_key    (in_tdata[KEY_W-1:0]),
    .in_data   (in_tdata[KEY_W+IN_DATA_W-1:KEY_W]),
    .capacity  (capacity_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  skte_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output stage
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.found_data, out_res_r.position};
  assign out_tuser  = out_res_r.status;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("failed request carries non-zero position or data");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before transfer");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("request taken while a result is still in the engine");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !res_valid)
    else $error("result produced in the cycle after a request transfer");
`endif

endmodule

// File: hdl/skte_ram.sv
module skte_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/skte_ctrl.sv
module skte_ctrl
  import skte_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  localparam int AW    = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int ENT_W = KEY_W + DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic [CAP_W-1:0]     capacity,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [ENT_W-1:0]     ram_wdata,
  output logic [AW-1:0]        ram_raddr,
  input  logic [ENT_W-1:0]     ram_rdata
);

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  ctl_state_t state_r, state_nxt;

  logic [FUNC_W-1:0]     func_r,  func_nxt;
  logic [KEY_W-1:0]      key_r,   key_nxt;
  logic [DATA_WIDTH-1:0] data_r,  data_nxt;
  logic [CNT_W-1:0]      lo_r,    lo_nxt;
  logic [CNT_W-1:0]      hi_r,    hi_nxt;
  logic [CNT_W-1:0]      mid_r,   mid_nxt;
  logic [CNT_W-1:0]      cnt_r,   cnt_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  hit_r,   hit_nxt;
  logic [DATA_WIDTH-1:0] hdata_r, hdata_nxt;
  res_t                  res_r,   res_nxt;

  logic [CNT_W-1:0]      mid;
  logic [KEY_W-1:0]      rd_key;
  logic [DATA_WIDTH-1:0] rd_dat;
  logic                  full;
  logic                  is_upsert;
  logic                  is_delete;
  logic                  del_move;
  logic                  ins_direct;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  ins_last;
  logic                  del_last;

  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key     = ram_rdata[ENT_W-1:DATA_WIDTH];
  assign rd_dat     = ram_rdata[DATA_WIDTH-1:0];
  assign full       = (CMP_W'(count_r) >= CMP_W'(capacity)) ||
                      (count_r == CNT_W'(TABLE_DEPTH));
  assign is_upsert  = (func_r == FN_UPSERT);
  assign is_delete  = (func_r == FN_DELETE);
  assign del_move   = ((hi_r + CNT_W'(1)) < count_r);
  assign ins_direct = (hi_r == count_r);
  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign ins_last   = (cnt_dec == hi_r);
  assign del_last   = ((cnt_inc + CNT_W'(1)) == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          state_nxt = CS_SEEK;
        end
      end
      CS_SEEK: begin
        state_nxt = (lo_r < hi_r) ? CS_CMP : CS_DECIDE;
      end
      CS_CMP: begin
        state_nxt = CS_SEEK;
      end
      CS_DECIDE: begin
        state_nxt = CS_DONE;
        if (is_upsert && !hit_r && !full) begin
          state_nxt = ins_direct ? CS_PUT : CS_MV_RD;
        end else if (is_delete && hit_r && del_move) begin
          state_nxt = CS_MV_RD;
        end
      end
      CS_MV_RD: begin
        state_nxt = CS_MV_WR;
      end
      CS_MV_WR: begin
        if (is_upsert) begin
          state_nxt = ins_last ? CS_PUT : CS_MV_RD;
        end else begin
          state_nxt = del_last ? CS_DONE : CS_MV_RD;
        end
      end
      CS_PUT: begin
        state_nxt = CS_DONE;
      end
      CS_DONE: begin
        if (res_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == CS_IDLE);
    res_valid = (state_r == CS_DONE);
    res       = res_r;
    ram_we    = 1'b0;
    ram_waddr = hi_r[AW-1:0];
    ram_wdata = {key_r, data_r};
    ram_raddr = mid[AW-1:0];
    unique case (state_r)
      CS_DECIDE: begin
        ram_we = is_upsert && hit_r;
      end
      CS_MV_RD: begin
        ram_raddr = is_upsert ? cnt_dec[AW-1:0] : cnt_inc[AW-1:0];
      end
      CS_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = ram_rdata;
      end
      CS_PUT: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    func_nxt  = func_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    hit_nxt   = hit_r;
    hdata_nxt = hdata_r;
    res_nxt   = res_r;
    case (state_r)
      CS_IDLE: begin
        func_nxt = in_func;
        key_nxt  = in_key;
        data_nxt = in_data[DATA_WIDTH-1:0];
        lo_nxt   = '0;
        hi_nxt   = count_r;
        hit_nxt  = 1'b0;
      end
      CS_SEEK: begin
        mid_nxt = mid;
      end
      CS_CMP: begin
        if (rd_key < key_r) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt    = mid_r;
          hit_nxt   = (rd_key == key_r);
          hdata_nxt = rd_dat;
        end
      end
      CS_DECIDE: begin
        res_nxt.status     = ST_OK;
        res_nxt.position   = POS_W'(hi_r);
        res_nxt.found_data = '0;
        case (func_r)
          FN_UPSERT: begin
            if (!hit_r && full) begin
              res_nxt.status   = ST_FULL;
              res_nxt.position = '0;
            end
          end
          FN_DELETE: begin
            if (!hit_r) begin
              res_nxt.status   = ST_NOT_FOUND;
              res_nxt.position = '0;
            end else if (!del_move) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          default: begin
            if (hit_r) begin
              res_nxt.found_data = FOUND_W'(hdata_r);
            end else begin
              res_nxt.status   = ST_NOT_FOUND;
              res_nxt.position = '0;
            end
          end
        endcase
        cnt_nxt = is_upsert ? count_r : hi_r;
      end
      CS_MV_WR: begin
        if (is_upsert) begin
          cnt_nxt = cnt_dec;
        end else begin
          cnt_nxt = cnt_inc;
          if (del_last) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      CS_PUT: begin
        count_nxt = count_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    key_r   <= key_nxt;
    data_r  <= data_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    cnt_r   <= cnt_nxt;
    hit_r   <= hit_nxt;
    hdata_r <= hdata_nxt;
    res_r   <= res_nxt;
  end

endmodule
